// File: design/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants of the Pearson correlation accumulator.
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam int unsigned MAX_SAMPLES = 32768;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [15:0] x_sample;
		logic signed [15:0] y_sample;
		logic               last_sample;
		logic        [15:0] column_index;
	} pca_in_t;

	typedef struct packed {
		logic signed [15:0] correlation;
		logic        [15:0] result_index;
		logic               undefined_flag;
	} pca_out_t;

	// finished sums of one column run
	typedef struct packed {
		logic        [15:0] count;
		logic signed [31:0] sum_x;
		logic signed [31:0] sum_y;
		logic signed [47:0] sum_xx;
		logic signed [47:0] sum_yy;
		logic signed [47:0] sum_xy;
		logic        [15:0] column;
	} pca_snap_t;

endpackage

// File: design/pca_front.sv
// ----------------------------------------------------------------------------
// pca_front
// Sample accumulator: one beat per cycle while the queue is not full, hands the sums of a run to the queue.
// ----------------------------------------------------------------------------
module pca_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  pca_pkg::pca_in_t    item,
	output logic                snap_push,
	output pca_pkg::pca_snap_t  snap
);

	logic        [15:0] count_q;
	logic signed [31:0] sum_x_q, sum_y_q;
	logic signed [47:0] sum_xx_q, sum_yy_q, sum_xy_q;

	logic               acc_en;
	logic signed [31:0] xx, yy, xy;
	pca_pkg::pca_snap_t nxt;

	assign acc_en = 32'(count_q) < pca_pkg::MAX_SAMPLES;
	assign xx = item.x_sample * item.x_sample;
	assign yy = item.y_sample * item.y_sample;
	assign xy = item.x_sample * item.y_sample;

	always_comb begin
		nxt.count  = count_q;
		nxt.sum_x  = sum_x_q;
		nxt.sum_y  = sum_y_q;
		nxt.sum_xx = sum_xx_q;
		nxt.sum_yy = sum_yy_q;
		nxt.sum_xy = sum_xy_q;
		nxt.column = item.column_index;
		if (acc_en) begin
			nxt.count  = count_q + 16'd1;
			nxt.sum_x  = sum_x_q + 32'(item.x_sample);
			nxt.sum_y  = sum_y_q + 32'(item.y_sample);
			nxt.sum_xx = sum_xx_q + 48'(xx);
			nxt.sum_yy = sum_yy_q + 48'(yy);
			nxt.sum_xy = sum_xy_q + 48'(xy);
		end
	end

	assign snap      = nxt;
	assign snap_push = accept & item.last_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else if (accept) begin
			if (item.last_sample) begin
				// run closed: start the next one from zero
				count_q  <= '0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
			end else begin
				count_q  <= nxt.count;
				sum_x_q  <= nxt.sum_x;
				sum_y_q  <= nxt.sum_y;
				sum_xx_q <= nxt.sum_xx;
				sum_yy_q <= nxt.sum_yy;
				sum_xy_q <= nxt.sum_xy;
			end
		end
	end

endmodule

// File: design/pca_fifo.sv
// ----------------------------------------------------------------------------
// pca_fifo
// Short queue of finished column sums between accumulator and solver.
// ----------------------------------------------------------------------------
module pca_fifo #(
	parameter int unsigned DEPTH = pca_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  pca_pkg::pca_snap_t  wr_data,
	output logic                full,
	input  logic                rd_en,
	output pca_pkg::pca_snap_t  rd_data,
	output logic                empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pca_pkg::pca_snap_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   level_q;
	logic               do_wr, do_rd;

	assign full    = level_q == CNT_W'(DEPTH);
	assign empty   = level_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// File: design/pca_mul.sv
// ----------------------------------------------------------------------------
// pca_mul
// Shift-add multiplier, 64 x 64 unsigned, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pca_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] product
);

	logic [127:0] a_q, p_q;
	logic [63:0]  b_q;
	logic         busy_q;

	// finishes as soon as no multiplier bits remain
	assign done    = busy_q & (b_q == '0);
	assign product = p_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= {64'd0, a};
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= {a_q[126:0], 1'b0};
			b_q <= {1'b0, b_q[63:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

endmodule

// File: design/pca_back.sv
// ----------------------------------------------------------------------------
// pca_back
// Column solver: forms numerator and denominators with a shared multiplier,
// divides, takes an integer square root and rounds to Q1.15.
// ----------------------------------------------------------------------------
module pca_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                snap_empty,
	input  pca_pkg::pca_snap_t  snap,
	output logic                snap_pop,
	output logic                busy,
	output logic                empty,
	input  logic                pop,
	output pca_pkg::pca_out_t   result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [2:0] OP_N_SXY = 3'd0;
	localparam logic [2:0] OP_SX_SY = 3'd1;
	localparam logic [2:0] OP_N_SXX = 3'd2;
	localparam logic [2:0] OP_SX_SX = 3'd3;
	localparam logic [2:0] OP_N_SYY = 3'd4;
	localparam logic [2:0] OP_SY_SY = 3'd5;
	localparam logic [2:0] OP_DX_DY = 3'd6;
	localparam logic [2:0] OP_NUM2  = 3'd7;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	logic [2:0]         state_q, op_q;
	logic               go_q;
	pca_pkg::pca_snap_t snap_q;
	logic signed [63:0] t_q, num_q, dx_q;
	logic [121:0]       den_q, rem_q;
	logic [32:0]        quo_q;
	logic [5:0]         cnt_q;
	logic [32:0]        sq_t_q;
	logic [33:0]        sq_r_q, sq_bit_q;
	logic [16:0]        s_q;
	logic               und_q;
	logic               out_valid_q;
	pca_pkg::pca_out_t  out_q;

	logic [63:0]        opa, opb, n64;
	logic signed [63:0] sx, sy, sxx, syy, sxy;
	logic               neg;
	logic               mdone;
	logic [127:0]       prod;
	logic signed [63:0] res, diff;
	logic [122:0]       cand;
	logic               dge;
	logic [33:0]        trial, r_nxt;
	logic               sge;
	logic [17:0]        s_inc;
	logic [16:0]        q;
	logic signed [15:0] corr;
	logic               out_free;

	assign n64 = 64'(snap_q.count);
	assign sx  = 64'(snap_q.sum_x);
	assign sy  = 64'(snap_q.sum_y);
	assign sxx = 64'(snap_q.sum_xx);
	assign syy = 64'(snap_q.sum_yy);
	assign sxy = 64'(snap_q.sum_xy);

	always_comb begin
		opa = n64;
		opb = mag64(sxy);
		neg = sxy[63];
		case (op_q)
			OP_N_SXY: begin
				opa = n64;
				opb = mag64(sxy);
				neg = sxy[63];
			end
			OP_SX_SY: begin
				opa = mag64(sx);
				opb = mag64(sy);
				neg = sx[63] ^ sy[63];
			end
			OP_N_SXX: begin
				opa = n64;
				opb = mag64(sxx);
				neg = sxx[63];
			end
			OP_SX_SX: begin
				opa = mag64(sx);
				opb = mag64(sx);
				neg = 1'b0;
			end
			OP_N_SYY: begin
				opa = n64;
				opb = mag64(syy);
				neg = syy[63];
			end
			OP_SY_SY: begin
				opa = mag64(sy);
				opb = mag64(sy);
				neg = 1'b0;
			end
			OP_DX_DY: begin
				opa = 64'(dx_q);
				opb = 64'(t_q);
				neg = 1'b0;
			end
			OP_NUM2: begin
				opa = mag64(num_q);
				opb = mag64(num_q);
				neg = 1'b0;
			end
			default: begin
				opa = n64;
				opb = mag64(sxy);
				neg = sxy[63];
			end
		endcase
	end

	pca_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (go_q),
		.a       (opa),
		.b       (opb),
		.done    (mdone),
		.product (prod)
	);

	assign res  = neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
	assign diff = t_q - res;

	// restoring division step: quotient bit 32 needs no shift
	assign cand = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign dge  = cand >= {1'b0, den_q};

	// digit-by-digit square root step
	assign trial = sq_r_q + sq_bit_q;
	assign sge   = {1'b0, sq_t_q} >= trial;
	assign r_nxt = sge ? ({1'b0, sq_r_q[33:1]} + sq_bit_q) : {1'b0, sq_r_q[33:1]};

	// largest odd k <= s gives q = (s + 1) / 2
	assign s_inc = {1'b0, s_q} + 18'd1;
	assign q     = s_inc[17:1];
	always_comb begin
		if (und_q) begin
			corr = '0;
		end else if (num_q[63]) begin
			corr = 16'(-$signed({1'b0, q}));
		end else if (q > 17'd32767) begin
			corr = 16'sd32767;
		end else begin
			corr = $signed(q[15:0]);
		end
	end

	assign out_free = ~out_valid_q | pop;
	assign snap_pop = (state_q == ST_IDLE) & ~snap_empty;
	assign busy     = state_q != ST_IDLE;
	assign empty    = ~out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk) begin
		if (snap_pop) begin
			snap_q <= snap;
		end
		case (state_q)
			ST_MUL: begin
				if (mdone) begin
					case (op_q)
						OP_N_SXY, OP_N_SXX, OP_N_SYY: t_q <= res;
						OP_SX_SY: num_q <= diff;
						OP_SX_SX: dx_q <= diff;
						OP_SY_SY: t_q <= diff;
						OP_DX_DY: den_q <= prod[121:0];
						OP_NUM2: begin
							rem_q <= prod[121:0];
							quo_q <= '0;
						end
						default: t_q <= res;
					endcase
				end
			end
			ST_DIV: begin
				rem_q  <= dge ? 122'(cand - {1'b0, den_q}) : cand[121:0];
				quo_q  <= {quo_q[31:0], dge};
				sq_t_q <= {quo_q[31:0], dge};
				sq_r_q <= '0;
				sq_bit_q <= 34'd1 << 32;
			end
			ST_SQRT: begin
				if (sge) begin
					sq_t_q <= 33'({1'b0, sq_t_q} - trial);
				end
				sq_r_q   <= r_nxt;
				sq_bit_q <= {2'b00, sq_bit_q[33:2]};
				s_q      <= r_nxt[16:0];
			end
			ST_OUT: begin
				if (out_free) begin
					out_q.correlation    <= corr;
					out_q.result_index   <= snap_q.column;
					out_q.undefined_flag <= und_q;
				end
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_N_SXY;
			go_q        <= 1'b0;
			cnt_q       <= '0;
			und_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!snap_empty) begin
						op_q    <= OP_N_SXY;
						go_q    <= 1'b1;
						und_q   <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mdone) begin
						if (op_q == OP_SY_SY && (dx_q <= 0 || diff <= 0)) begin
							und_q   <= 1'b1;
							state_q <= ST_OUT;
						end else if (op_q == OP_NUM2) begin
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							op_q <= op_q + 3'd1;
							go_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_bit_q[0]) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/pearson_correlation_accumulator.sv
// A sample beat is summed in the cycle it is taken. After the last beat of a column,
// the solver forms its result with up to eight products on one shift-add multiplier
// (one bit per cycle), then 33 divide and 17 root steps; a busy solver or held result
// delays it. Throughput: one sample beat per cycle while the queue is not full;
// columns queue while the solver works.
// Reset clears the sums, the queue and the result valid flag.
// ----------------------------------------------------------------------------
// pearson_correlation_accumulator
// Streaming Pearson correlation of a column against a vector, Q1.15 result.
// ----------------------------------------------------------------------------
module pearson_correlation_accumulator #(
	parameter int unsigned QUEUE_DEPTH = pca_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pca_pkg::pca_in_t   item,
	output logic               empty,
	input  logic               pop,
	output pca_pkg::pca_out_t  result
);

	logic               accept;
	logic               snap_push, snap_pop, snap_empty, back_busy;
	pca_pkg::pca_snap_t snap_in, snap_out;

	assign accept = push & ~full;

	pca_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.snap_push (snap_push),
		.snap      (snap_in)
	);

	pca_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (snap_push),
		.wr_data (snap_in),
		.full    (full),
		.rd_en   (snap_pop),
		.rd_data (snap_out),
		.empty   (snap_empty)
	);

	pca_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_empty (snap_empty),
		.snap       (snap_out),
		.snap_pop   (snap_pop),
		.busy       (back_busy),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

`ifndef SYNTHESIS
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.undefined_flag) |-> (result.correlation == 16'sd0))
		else $error("undefined result carries nonzero correlation");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_sample) |=> (!snap_empty || back_busy))
		else $error("closed column run was not handed to the solver");
`endif

endmodule
